>>> sv/cfg_crc_pkg.sv
// Shared types and constants for the configurable CRC engine.
// Used by cfg_crc_cell and configurable_crc_engine; no dependencies.
package cfg_crc_pkg;

  // Fixed field widths
  localparam int ORDER_W     = 5;
  localparam int POLY_W      = 25;
  localparam int CHECKSUM_W  = 24;
  localparam int DATA_W      = 8;
  localparam int BYTE_BITS   = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = POLY_W;

  // Default size of the cell row
  localparam int DEF_MAX_ORDER = 24;

  // Register reset values
  localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(24);
  localparam logic [POLY_W-1:0]  POLY_RST  = POLY_W'(25578747);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER = 1'b0,
    REG_POLY  = 1'b1
  } cfg_reg_t;

  // Input item modes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_BIT  = 1'b1;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic                 load;   // request accepted this cycle
    logic                 clear;  // request ends the message
    logic [BYTE_BITS-1:0] act;    // shift step k takes part
    logic [BYTE_BITS-1:0] fb;     // feedback bit of shift step k
  } cell_ctl_t;

endpackage

>>> sv/cfg_crc_cell.sv
// One bit slice of the CRC shift register: holds one remainder bit and
// runs it through the eight shift steps of a byte. Depends on cfg_crc_pkg.
module cfg_crc_cell
  import cfg_crc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic                 live,      // bit lies below the current order
  input  logic                 poly_bit,  // generator coefficient of this bit
  input  logic [BYTE_BITS-1:0] nb_in,     // lower neighbor at each step
  output logic [BYTE_BITS:0]   st_out,    // this bit at steps 0..8
  output logic                 bit_o
);

  logic rem_r;
  logic rem_nxt;
  logic [BYTE_BITS:0] st;

  // Step through the byte: take the neighbor's bit, fold in the feedback
  always_comb begin
    st[0] = live & rem_r;
    for (int k = 0; k < BYTE_BITS; k++) begin
      if (ctl.act[k]) begin
        st[k+1] = live & (nb_in[k] ^ (ctl.fb[k] & poly_bit));
      end else begin
        st[k+1] = st[k];
      end
    end
  end

  // Clear at the end of a message, else keep the shifted bit
  assign rem_nxt = ctl.clear ? 1'b0 : st[BYTE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 1'b0;
    end else if (ctl.load) begin
      rem_r <= rem_nxt;
    end
  end

  assign st_out = st;
  assign bit_o  = rem_r;

endmodule

>>> sv/configurable_crc_engine.sv
// Configurable MSB-first CRC engine (order 1..MAX_ORDER, any generator).
// A checksum appears on out_ in the cycle after the request marked last is taken.
// Throughput: one request per cycle, byte or bit, while out_ is not stalled. The
// cells run a byte's eight shift steps (step 0 alone for a bit) in the accept cycle.
// Reset (rst_n low, synchronous): remainder cleared, order 24, polynomial 0x1864CFB.
module configurable_crc_engine
  import cfg_crc_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [7:0] data
  input  logic                  in_tuser,   // [0] mode
  input  logic                  in_tlast,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CHECKSUM_W-1:0] out_tdata   // [23:0] checksum
);

  logic [ORDER_W-1:0]    crc_order_r;
  logic [POLY_W-1:0]     crc_poly_r;
  logic                  out_valid_r;
  logic [CHECKSUM_W-1:0] out_data_r;

  logic                  in_acc;
  logic [ORDER_W-1:0]    eff_ord;
  logic [MAX_ORDER-1:0]  live;
  logic [MAX_ORDER-1:0]  top_sel;
  logic [MAX_ORDER-1:0]  poly_ext;
  logic [MAX_ORDER-1:0]  rem_bits;
  logic [BYTE_BITS-1:0]  din;
  logic [CHECKSUM_W-1:0] checksum;
  cell_ctl_t             ctl;

  logic [BYTE_BITS:0]    st  [MAX_ORDER];
  logic [MAX_ORDER-1:0]  col [BYTE_BITS];

  // Configuration registers; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_order_r <= ORDER_RST;
      crc_poly_r  <= POLY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORDER: crc_order_r <= cfg_data[ORDER_W-1:0];
        REG_POLY:  crc_poly_r  <= cfg_data[POLY_W-1:0];
        default:   ;
      endcase
    end
  end

  // Clamp the order into 1..MAX_ORDER
  always_comb begin
    if (crc_order_r == '0) begin
      eff_ord = ORDER_W'(1);
    end else if (crc_order_r > ORDER_W'(MAX_ORDER)) begin
      eff_ord = ORDER_W'(MAX_ORDER);
    end else begin
      eff_ord = crc_order_r;
    end
  end

  // Per-bit order mask, top-bit select and generator coefficient
  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_bitctl
    assign live[i]    = ORDER_W'(i) < eff_ord;
    assign top_sel[i] = ORDER_W'(i + 1) == eff_ord;
    if (i < POLY_W) begin : g_pb
      assign poly_ext[i] = crc_poly_r[i];
    end else begin : g_pz
      assign poly_ext[i] = 1'b0;
    end
  end

  // Message bits per step: MSB first for a byte, bit 0 alone in bit mode
  for (genvar k = 0; k < BYTE_BITS; k++) begin : g_din
    if (k == 0) begin : g_first
      assign din[k] = (in_tuser == MODE_BIT) ? in_tdata[0] : in_tdata[BYTE_BITS-1];
    end else begin : g_rest
      assign din[k] = (in_tuser == MODE_BIT) ? 1'b0 : in_tdata[BYTE_BITS-1-k];
    end
  end

  // Feedback of each step: top live bit of that step xor message bit
  for (genvar k = 0; k < BYTE_BITS; k++) begin : g_fb
    for (genvar i = 0; i < MAX_ORDER; i++) begin : g_col
      assign col[k][i] = st[i][k];
    end
    assign ctl.fb[k] = din[k] ^ (|(col[k] & top_sel));
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign ctl.load  = in_acc;
  assign ctl.clear = in_tlast;
  assign ctl.act   = (in_tuser == MODE_BIT) ? BYTE_BITS'(1) : '1;

  // Row of bit cells, each fed by its lower neighbor
  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
    logic [BYTE_BITS-1:0] nb;
    if (i == 0) begin : g_lsb
      assign nb = '0;
    end else begin : g_mid
      assign nb = st[i-1][BYTE_BITS-1:0];
    end
    cfg_crc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .live     (live[i]),
      .poly_bit (poly_ext[i]),
      .nb_in    (nb),
      .st_out   (st[i]),
      .bit_o    (rem_bits[i])
    );
  end

  // Gather the final step into the checksum width
  for (genvar j = 0; j < CHECKSUM_W; j++) begin : g_sum
    if (j < MAX_ORDER) begin : g_on
      assign checksum[j] = st[j][BYTE_BITS];
    end else begin : g_off
      assign checksum[j] = 1'b0;
    end
  end

  // Output register: load on a last request, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_data_r <= checksum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A last request always produces a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> out_tvalid)
    else $error("last request did not produce a checksum");

  // A new result only follows a last request
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) && out_valid_r) |-> $past(in_acc && in_tlast))
    else $error("checksum without a last request");

  // The remainder restarts from zero after each message
  a_rem_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (rem_bits == '0))
    else $error("remainder not cleared after message end");

  // Bits at and above the order stay zero in the checksum
  a_sum_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> ((out_data_r[CHECKSUM_W-1:1] >> ($past(eff_ord) - 1'b1)) == '0))
    else $error("checksum has bits above the order");

endmodule
